// ===== design/hgfp_pkg.sv =====
package hgfp_pkg;

  // Grid geometry and data widths.
  localparam int POINT_BITS  = 12;
  localparam int MAX_POINTS  = 1 << POINT_BITS;
  localparam int HEIGHT_BITS = 16;
  localparam int ROW_BITS    = POINT_BITS + 1;
  localparam int TOL_BITS    = 16;
  // Candidate neighbor indexes are signed and may fall off either end of the grid.
  localparam int CAND_BITS   = POINT_BITS + 3;

  // Visited tags: an entry counts as visited when its tag equals the current walk tag.
  localparam int EPOCH_BITS  = 8;
  localparam logic [EPOCH_BITS-1:0] EPOCH_FIRST = EPOCH_BITS'(1);
  localparam logic [EPOCH_BITS-1:0] EPOCH_LAST  = {EPOCH_BITS{1'b1}};

  // Column divider: quotient bits retired per cycle.
  localparam int DIV_BITS  = 4;
  localparam int DIV_STEPS = POINT_BITS / DIV_BITS;

  // Configuration port.
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_ROW_LENGTH  = 2'd0,
    CFG_POINT_TOTAL = 2'd1,
    CFG_CLIMB_TOL   = 2'd2
  } hgfp_cfg_idx_t;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_START = 2'd1,
    CMD_STEP  = 2'd2
  } hgfp_cmd_t;

  typedef struct packed {
    hgfp_cmd_t               command;
    logic [POINT_BITS-1:0]   point_index;
    logic [HEIGHT_BITS-1:0]  height_value;
  } hgfp_in_t;

  typedef struct packed {
    logic [POINT_BITS-1:0] from_point;
    logic [POINT_BITS-1:0] to_point;
    logic                  moved;
    logic                  walk_done;
  } hgfp_out_t;

  // Effective configuration: row length never zero, point total clamped to the store.
  typedef struct packed {
    logic [ROW_BITS-1:0] row_length;
    logic [ROW_BITS-1:0] point_total;
    logic [TOL_BITS-1:0] climb_tolerance;
  } hgfp_cfg_t;

  typedef struct packed {
    logic                  start;
    logic [POINT_BITS-1:0] dividend;
    logic [ROW_BITS-1:0]   divisor;
  } hgfp_div_req_t;

  typedef struct packed {
    logic                  done;
    logic [POINT_BITS-1:0] remainder;
  } hgfp_div_rsp_t;

endpackage

// ===== design/hgfp_ram.sv =====
module hgfp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/hgfp_div.sv =====
module hgfp_div (
  input  logic                   clk,
  input  logic                   rst_n,
  input  hgfp_pkg::hgfp_div_req_t req,
  output hgfp_pkg::hgfp_div_rsp_t rsp
);

  localparam int CNT_BITS = $clog2(hgfp_pkg::DIV_STEPS);

  logic                              busy_r, busy_nxt;
  logic                              done_r, done_nxt;
  logic [CNT_BITS-1:0]               cnt_r, cnt_nxt;
  logic [hgfp_pkg::ROW_BITS-1:0]     rem_r, rem_nxt;
  logic [hgfp_pkg::POINT_BITS-1:0]   num_r, num_nxt;
  logic [hgfp_pkg::ROW_BITS-1:0]     den_r, den_nxt;
  logic [hgfp_pkg::ROW_BITS-1:0]     rem_step;
  logic [hgfp_pkg::POINT_BITS-1:0]   num_step;

  // Restoring division, several quotient bits per cycle; only the remainder is kept.
  always_comb begin
    rem_step = rem_r;
    num_step = num_r;
    for (int i = 0; i < hgfp_pkg::DIV_BITS; i++) begin
      rem_step = {rem_step[hgfp_pkg::ROW_BITS-2:0], num_step[hgfp_pkg::POINT_BITS-1]};
      num_step = {num_step[hgfp_pkg::POINT_BITS-2:0], 1'b0};
      if (rem_step >= den_r) begin
        rem_step = rem_step - den_r;
      end
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = done_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    num_nxt  = num_r;
    den_nxt  = den_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      num_nxt  = req.dividend;
      den_nxt  = req.divisor;
    end else if (busy_r) begin
      rem_nxt = rem_step;
      num_nxt = num_step;
      cnt_nxt = CNT_BITS'(cnt_r + 1'b1);
      if (cnt_r == CNT_BITS'(hgfp_pkg::DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    num_r <= num_nxt;
    den_r <= den_nxt;
  end

  assign rsp.done      = done_r;
  assign rsp.remainder = rem_r[hgfp_pkg::POINT_BITS-1:0];

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (rem_r < den_r))
    else $error("column remainder not below the row length");

endmodule

// ===== design/hgfp_ctrl.sv =====
module hgfp_ctrl (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_fire,
  input  hgfp_pkg::hgfp_in_t                  in_data,
  output logic                                busy,
  input  hgfp_pkg::hgfp_cfg_t                 cfg,
  output hgfp_pkg::hgfp_div_req_t             div_req,
  input  hgfp_pkg::hgfp_div_rsp_t             div_rsp,
  output logic [hgfp_pkg::POINT_BITS-1:0]     rd_addr,
  input  logic [hgfp_pkg::HEIGHT_BITS-1:0]    hgt_rdata,
  input  logic [hgfp_pkg::EPOCH_BITS-1:0]     vis_rdata,
  output logic                                hgt_we,
  output logic [hgfp_pkg::POINT_BITS-1:0]     hgt_waddr,
  output logic [hgfp_pkg::HEIGHT_BITS-1:0]    hgt_wdata,
  output logic                                vis_we,
  output logic [hgfp_pkg::POINT_BITS-1:0]     vis_waddr,
  output logic [hgfp_pkg::EPOCH_BITS-1:0]     vis_wdata,
  input  logic                                out_free,
  output logic                                res_valid,
  output hgfp_pkg::hgfp_out_t                 res_data
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CUR,
    ST_CAND,
    ST_LAST,
    ST_FINISH
  } st_t;

  // Neighbor visiting order.
  typedef enum logic [2:0] {
    NB_UP,
    NB_DOWN,
    NB_DOWN_LEFT,
    NB_UP_LEFT,
    NB_LEFT,
    NB_RIGHT,
    NB_UP_RIGHT,
    NB_DOWN_RIGHT
  } nb_t;

  localparam int PB = hgfp_pkg::POINT_BITS;
  localparam int HB = hgfp_pkg::HEIGHT_BITS;
  localparam int CB = hgfp_pkg::CAND_BITS;

  st_t                            state_r, state_nxt;
  nb_t                            k_r, k_nxt;
  hgfp_pkg::hgfp_cmd_t            cmd_r, cmd_nxt;
  logic [PB-1:0]                  idx_r, idx_nxt;
  logic [HB-1:0]                  hval_r, hval_nxt;
  logic [PB-1:0]                  cur_r, cur_nxt;
  logic                           fin_r, fin_nxt;
  logic [hgfp_pkg::EPOCH_BITS-1:0] epoch_r, epoch_nxt;
  logic [PB-1:0]                  clr_cnt_r, clr_cnt_nxt;
  logic                           lim_pend_r, lim_pend_nxt;
  logic [HB:0]                    limit_r, limit_nxt;
  logic                           ev_vld_r, ev_vld_nxt;
  logic [PB-1:0]                  ev_id_r, ev_id_nxt;
  logic                           found_r, found_nxt;
  logic [HB-1:0]                  best_h_r, best_h_nxt;
  logic [PB-1:0]                  best_id_r, best_id_nxt;

  logic signed [CB-1:0] cur_ext, w_ext, total_ext, row_term, col_term, cand_id;
  logic                 need_left, need_right, col_ok, slot_ok, hold, take, commit;

  assign cur_ext   = signed'(CB'(cur_r));
  assign w_ext     = signed'(CB'(cfg.row_length));
  assign total_ext = signed'(CB'(cfg.point_total));

  always_comb begin
    row_term   = '0;
    col_term   = '0;
    need_left  = 1'b0;
    need_right = 1'b0;
    case (k_r)
      NB_UP:         begin row_term = -w_ext; end
      NB_DOWN:       begin row_term = w_ext; end
      NB_DOWN_LEFT:  begin row_term = w_ext;  col_term = -CB'(1); need_left = 1'b1; end
      NB_UP_LEFT:    begin row_term = -w_ext; col_term = -CB'(1); need_left = 1'b1; end
      NB_LEFT:       begin col_term = -CB'(1); need_left = 1'b1; end
      NB_RIGHT:      begin col_term = CB'(1); need_right = 1'b1; end
      NB_UP_RIGHT:   begin row_term = -w_ext; col_term = CB'(1); need_right = 1'b1; end
      NB_DOWN_RIGHT: begin row_term = w_ext;  col_term = CB'(1); need_right = 1'b1; end
      default:       begin row_term = '0; end
    endcase
  end

  assign cand_id = cur_ext + row_term + col_term;

  always_comb begin
    col_ok = 1'b1;
    if (need_left) begin
      col_ok = (div_rsp.remainder != '0);
    end else if (need_right) begin
      col_ok = ((hgfp_pkg::ROW_BITS'(div_rsp.remainder) + hgfp_pkg::ROW_BITS'(1))
                < cfg.row_length);
    end
  end

  assign slot_ok = !cand_id[CB-1] && (cand_id < total_ext) && col_ok;
  // Side and diagonal neighbors need the column, which the divider supplies.
  assign hold    = (need_left || need_right) && !div_rsp.done;

  assign rd_addr = (state_r == ST_CAND) ? cand_id[PB-1:0] : cur_r;

  // A candidate read issued last cycle is judged against the running best.
  assign take = ev_vld_r && ((HB+1)'(hgt_rdata) <= limit_r) && (vis_rdata != epoch_r)
                && (!found_r || (hgt_rdata < best_h_r));

  assign commit = (state_r == ST_FINISH) && out_free;

  always_comb begin
    state_nxt    = state_r;
    k_nxt        = k_r;
    cmd_nxt      = cmd_r;
    idx_nxt      = idx_r;
    hval_nxt     = hval_r;
    cur_nxt      = cur_r;
    fin_nxt      = fin_r;
    epoch_nxt    = epoch_r;
    clr_cnt_nxt  = clr_cnt_r;
    lim_pend_nxt = 1'b0;
    limit_nxt    = limit_r;
    ev_vld_nxt   = 1'b0;
    ev_id_nxt    = ev_id_r;
    found_nxt    = found_r;
    best_h_nxt   = best_h_r;
    best_id_nxt  = best_id_r;

    if (lim_pend_r) begin
      limit_nxt = (HB+1)'(hgt_rdata) + (HB+1)'(cfg.climb_tolerance);
    end
    if (take) begin
      found_nxt   = 1'b1;
      best_h_nxt  = hgt_rdata;
      best_id_nxt = ev_id_r;
    end

    case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = PB'(clr_cnt_r + 1'b1);
        if (clr_cnt_r == {PB{1'b1}}) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          cmd_nxt  = in_data.command;
          idx_nxt  = in_data.point_index;
          hval_nxt = in_data.height_value;
          if ((in_data.command == hgfp_pkg::CMD_STEP) && !fin_r) begin
            state_nxt = ST_CUR;
          end else begin
            state_nxt = ST_FINISH;
          end
        end
      end
      ST_CUR: begin
        found_nxt    = 1'b0;
        lim_pend_nxt = 1'b1;
        k_nxt        = NB_UP;
        state_nxt    = ST_CAND;
      end
      ST_CAND: begin
        if (!hold) begin
          ev_vld_nxt = slot_ok;
          ev_id_nxt  = cand_id[PB-1:0];
          if (k_r == NB_DOWN_RIGHT) begin
            state_nxt = ST_LAST;
          end else begin
            k_nxt = nb_t'(3'(k_r + 3'd1));
          end
        end
      end
      ST_LAST: begin
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
          case (cmd_r)
            hgfp_pkg::CMD_START: begin
              cur_nxt = idx_r;
              fin_nxt = 1'b0;
              if (epoch_r == hgfp_pkg::EPOCH_LAST) begin
                epoch_nxt   = hgfp_pkg::EPOCH_FIRST;
                clr_cnt_nxt = '0;
                state_nxt   = ST_CLEAR;
              end else begin
                epoch_nxt = hgfp_pkg::EPOCH_BITS'(epoch_r + 1'b1);
              end
            end
            hgfp_pkg::CMD_STEP: begin
              if (!fin_r) begin
                if (found_r) begin
                  cur_nxt = best_id_r;
                end else begin
                  fin_nxt = 1'b1;
                end
              end
            end
            default: begin
              cur_nxt = cur_r;
            end
          endcase
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      k_r        <= NB_UP;
      cur_r      <= '0;
      fin_r      <= 1'b1;
      epoch_r    <= hgfp_pkg::EPOCH_FIRST;
      clr_cnt_r  <= '0;
      lim_pend_r <= 1'b0;
      ev_vld_r   <= 1'b0;
      found_r    <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      k_r        <= k_nxt;
      cur_r      <= cur_nxt;
      fin_r      <= fin_nxt;
      epoch_r    <= epoch_nxt;
      clr_cnt_r  <= clr_cnt_nxt;
      lim_pend_r <= lim_pend_nxt;
      ev_vld_r   <= ev_vld_nxt;
      found_r    <= found_nxt;
    end
    cmd_r     <= cmd_nxt;
    idx_r     <= idx_nxt;
    hval_r    <= hval_nxt;
    limit_r   <= limit_nxt;
    ev_id_r   <= ev_id_nxt;
    best_h_r  <= best_h_nxt;
    best_id_r <= best_id_nxt;
  end

  assign busy = (state_r != ST_IDLE);

  assign div_req.start    = in_fire && (in_data.command == hgfp_pkg::CMD_STEP);
  assign div_req.dividend = cur_r;
  assign div_req.divisor  = cfg.row_length;

  assign hgt_we    = commit && (cmd_r == hgfp_pkg::CMD_LOAD);
  assign hgt_waddr = idx_r;
  assign hgt_wdata = hval_r;

  assign vis_we    = (state_r == ST_CLEAR)
                     || (commit && (cmd_r == hgfp_pkg::CMD_STEP) && !fin_r && found_r);
  assign vis_waddr = (state_r == ST_CLEAR) ? clr_cnt_r : best_id_r;
  assign vis_wdata = (state_r == ST_CLEAR) ? '0 : epoch_r;

  assign res_valid = commit;

  always_comb begin
    res_data.from_point = cur_r;
    res_data.to_point   = cur_r;
    res_data.moved      = 1'b0;
    res_data.walk_done  = fin_r;
    case (cmd_r)
      hgfp_pkg::CMD_START: begin
        res_data.from_point = idx_r;
        res_data.to_point   = idx_r;
        res_data.walk_done  = 1'b0;
      end
      hgfp_pkg::CMD_STEP: begin
        if (!fin_r && found_r) begin
          res_data.to_point  = best_id_r;
          res_data.moved     = 1'b1;
          res_data.walk_done = 1'b0;
        end else begin
          res_data.walk_done = 1'b1;
        end
      end
      default: begin
        res_data.moved = 1'b0;
      end
    endcase
  end

  a_mark_not_current: assert property (@(posedge clk) disable iff (!rst_n)
    (vis_we && (state_r == ST_FINISH)) |-> (vis_waddr != cur_r))
    else $error("walk marked its own current point");

  a_best_within_limit: assert property (@(posedge clk) disable iff (!rst_n)
    found_r |-> ((HB+1)'(best_h_r) <= limit_r))
    else $error("chosen neighbor lies above the climb limit");

  a_column_in_time: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_CAND) && (k_r == NB_DOWN_LEFT)) |-> div_rsp.done)
    else $error("column not ready when side neighbors are reached");

endmodule

// ===== design/height_grid_flow_path_tracer_core.sv =====
// Sequence: a load, start or unused command, or a step of a finished walk, goes from its
// transfer straight to commit; a step of an active walk reads the current height, then the
// eight neighbors through the registered-read height and visited memories, then passes one
// compare stage and commits. Flow: a command is taken only while the controller is idle,
// never before the previous one has committed; the eight neighbor reads share one read port.
// Reset: synchronous, active low. After reset the visited memory is swept with in_stall high;
// the same sweep follows every 255th start command when the walk tag wraps.
module height_grid_flow_path_tracer_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  hgfp_pkg::hgfp_in_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output hgfp_pkg::hgfp_out_t                 out_data,
  input  logic                                cfg_we,
  input  logic [hgfp_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [hgfp_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);

  localparam int RB = hgfp_pkg::ROW_BITS;

  // Configuration registers, holding the low ROW_BITS or TOL_BITS bits of each write.
  logic [RB-1:0]                 row_len_r, row_len_nxt;
  logic [RB-1:0]                 pt_total_r, pt_total_nxt;
  logic [hgfp_pkg::TOL_BITS-1:0] tol_r, tol_nxt;
  hgfp_pkg::hgfp_cfg_t           cfg_eff;

  // Result register: it parts the controller from the output channel, so a new item is
  // taken while the previous result still waits for its transfer.
  logic                out_valid_r, out_valid_nxt;
  hgfp_pkg::hgfp_out_t out_data_r, out_data_nxt;
  logic                out_free;

  logic                            in_fire;
  logic                            busy;
  hgfp_pkg::hgfp_div_req_t         div_req;
  hgfp_pkg::hgfp_div_rsp_t         div_rsp;
  logic [hgfp_pkg::POINT_BITS-1:0] rd_addr;
  logic [hgfp_pkg::HEIGHT_BITS-1:0] hgt_rdata, hgt_wdata;
  logic [hgfp_pkg::EPOCH_BITS-1:0] vis_rdata, vis_wdata;
  logic                            hgt_we, vis_we;
  logic [hgfp_pkg::POINT_BITS-1:0] hgt_waddr, vis_waddr;
  logic                            res_valid;
  hgfp_pkg::hgfp_out_t             res_data;

  always_comb begin
    row_len_nxt  = row_len_r;
    pt_total_nxt = pt_total_r;
    tol_nxt      = tol_r;
    if (cfg_we) begin
      case (cfg_index)
        hgfp_pkg::CFG_ROW_LENGTH:  begin row_len_nxt  = cfg_wdata[RB-1:0]; end
        hgfp_pkg::CFG_POINT_TOTAL: begin pt_total_nxt = cfg_wdata[RB-1:0]; end
        hgfp_pkg::CFG_CLIMB_TOL:   begin tol_nxt = cfg_wdata[hgfp_pkg::TOL_BITS-1:0]; end
        default:                   begin tol_nxt = tol_r; end
      endcase
    end
  end

  // A zero row length behaves as one; a point total beyond the store is clamped to it.
  assign cfg_eff.row_length      = (row_len_r == '0) ? RB'(1) : row_len_r;
  assign cfg_eff.point_total     = (pt_total_r > RB'(hgfp_pkg::MAX_POINTS))
                                   ? RB'(hgfp_pkg::MAX_POINTS) : pt_total_r;
  assign cfg_eff.climb_tolerance = tol_r;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (res_valid) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res_data;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_len_r   <= RB'(64);
      pt_total_r  <= RB'(4096);
      tol_r       <= hgfp_pkg::TOL_BITS'(100);
      out_valid_r <= 1'b0;
    end else begin
      row_len_r   <= row_len_nxt;
      pt_total_r  <= pt_total_nxt;
      tol_r       <= tol_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  // The controller takes an item only while it is idle.
  assign in_stall  = busy;
  assign in_fire   = in_valid && !busy;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Heights are never cleared: reading a point that was never loaded is the user's concern.
  hgfp_ram #(
    .WIDTH(hgfp_pkg::HEIGHT_BITS),
    .DEPTH(hgfp_pkg::MAX_POINTS)
  ) u_height_ram (
    .clk   (clk),
    .we    (hgt_we),
    .waddr (hgt_waddr),
    .wdata (hgt_wdata),
    .raddr (rd_addr),
    .rdata (hgt_rdata)
  );

  // Visited map as walk tags: a start bumps the tag and clears the entries only when it wraps.
  hgfp_ram #(
    .WIDTH(hgfp_pkg::EPOCH_BITS),
    .DEPTH(hgfp_pkg::MAX_POINTS)
  ) u_visit_ram (
    .clk   (clk),
    .we    (vis_we),
    .waddr (vis_waddr),
    .wdata (vis_wdata),
    .raddr (rd_addr),
    .rdata (vis_rdata)
  );

  // Column of the current point, computed alongside the first neighbor reads of a step.
  hgfp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  hgfp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .in_data   (in_data),
    .busy      (busy),
    .cfg       (cfg_eff),
    .div_req   (div_req),
    .div_rsp   (div_rsp),
    .rd_addr   (rd_addr),
    .hgt_rdata (hgt_rdata),
    .vis_rdata (vis_rdata),
    .hgt_we    (hgt_we),
    .hgt_waddr (hgt_waddr),
    .hgt_wdata (hgt_wdata),
    .vis_we    (vis_we),
    .vis_waddr (vis_waddr),
    .vis_wdata (vis_wdata),
    .out_free  (out_free),
    .res_valid (res_valid),
    .res_data  (res_data)
  );

endmodule

// ===== test/testbench.sv =====
module testbench;

  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 10;
  // Longest stretch without any transfer: the visited-map sweep after reset or a tag wrap,
  // a long receiver hold-off and a few slow steps, with margin on top.
  localparam int QUIET_LIMIT   = 20000;
  localparam int SETTLE_CYCLES = 40;
  localparam int REPORT_LIMIT  = 10;
  localparam int TOTAL_ITEMS   = 1200;
  localparam int LONG_HOLD     = 400;
  localparam int SHAPED_POINTS = 48;

  localparam int MAX_POINTS  = hgfp_pkg::MAX_POINTS;
  localparam int POINT_BITS  = hgfp_pkg::POINT_BITS;
  localparam int HEIGHT_BITS = hgfp_pkg::HEIGHT_BITS;
  localparam int ROW_BITS    = hgfp_pkg::ROW_BITS;
  localparam int TOL_BITS    = hgfp_pkg::TOL_BITS;

  // The command field is two bits wide; the fourth code writes nothing.
  localparam hgfp_pkg::hgfp_cmd_t CMD_UNUSED = hgfp_pkg::hgfp_cmd_t'(2'd3);

  typedef enum int {
    TERRAIN_NOISE,
    TERRAIN_BAND,
    TERRAIN_FLAT,
    TERRAIN_SLOPE,
    TERRAIN_CLIFF
  } terrain_t;

  logic                                clk       = 1'b0;
  logic                                rst_n     = 1'b0;
  logic                                in_valid  = 1'b0;
  logic                                in_stall;
  hgfp_pkg::hgfp_in_t                  in_data   = '0;
  logic                                out_valid;
  logic                                out_stall = 1'b0;
  hgfp_pkg::hgfp_out_t                 out_data;
  logic                                cfg_we    = 1'b0;
  logic [hgfp_pkg::CFG_IDX_BITS-1:0]   cfg_index = '0;
  logic [hgfp_pkg::CFG_DATA_BITS-1:0]  cfg_wdata = '0;

  height_grid_flow_path_tracer_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #CLK_HALF clk = ~clk;

  // ---------------------------------------------------------------------------
  // Walker model. It keeps its own copy of the height grid, the visited marks,
  // the walker position and the configuration, and is advanced once per
  // accepted input transfer.
  // ---------------------------------------------------------------------------
  logic [HEIGHT_BITS-1:0] grid_height [MAX_POINTS];
  bit                     trail_mark  [MAX_POINTS];
  logic [POINT_BITS-1:0]  walker_at   = '0;
  bit                     walk_over   = 1'b1;
  logic [ROW_BITS-1:0]    row_len_set = ROW_BITS'(64);
  logic [ROW_BITS-1:0]    total_set   = ROW_BITS'(4096);
  logic [TOL_BITS-1:0]    climb_set   = TOL_BITS'(100);

  // A row length of zero behaves as a single column.
  function automatic int eff_row();
    return (row_len_set == 0) ? 1 : int'(row_len_set);
  endfunction

  // A point total above the store size is clamped to the store.
  function automatic int eff_total();
    return (total_set > MAX_POINTS) ? MAX_POINTS : int'(total_set);
  endfunction

  function automatic hgfp_pkg::hgfp_out_t predict_move(hgfp_pkg::hgfp_in_t item);
    hgfp_pkg::hgfp_out_t res;
    int        cand [8];
    int        w, total, cur, col, n, id, h, limit, margin, best, best_margin;
    bit        found;
    res.from_point = walker_at;
    res.to_point   = walker_at;
    res.moved      = 1'b0;
    res.walk_done  = walk_over;
    case (item.command)
      hgfp_pkg::CMD_LOAD: begin
        grid_height[item.point_index] = item.height_value;
      end
      hgfp_pkg::CMD_START: begin
        // The start point itself is left unmarked, so a walk may step back onto it.
        foreach (trail_mark[p]) trail_mark[p] = 1'b0;
        walker_at      = item.point_index;
        walk_over      = 1'b0;
        res.from_point = item.point_index;
        res.to_point   = item.point_index;
        res.walk_done  = 1'b0;
      end
      hgfp_pkg::CMD_STEP: begin
        if (!walk_over) begin
          w     = eff_row();
          total = eff_total();
          cur   = int'(walker_at);
          col   = cur % w;
          // Neighbor order: up, down, then the left side (down-left, up-left, left)
          // when not in the first column, then the right side (right, up-right,
          // down-right) when not in the last column.
          cand[0] = cur - w;
          cand[1] = cur + w;
          n = 2;
          if (col > 0) begin
            cand[n]     = cur + w - 1;
            cand[n + 1] = cur - w - 1;
            cand[n + 2] = cur - 1;
            n = n + 3;
          end
          if (col < w - 1) begin
            cand[n]     = cur + 1;
            cand[n + 1] = cur - w + 1;
            cand[n + 2] = cur + w + 1;
            n = n + 3;
          end
          limit       = int'(grid_height[cur]) + int'(climb_set);
          found       = 1'b0;
          best        = 0;
          best_margin = 0;
          for (int i = 0; i < n; i++) begin
            id = cand[i];
            if (id >= 0 && id < total) begin
              h = int'(grid_height[id]);
              if (h <= limit && !trail_mark[id]) begin
                margin = limit - h;
                // Strictly larger margin only, so the earlier neighbor keeps a tie.
                if (!found || margin > best_margin) begin
                  found       = 1'b1;
                  best_margin = margin;
                  best        = id;
                end
              end
            end
          end
          if (found) begin
            trail_mark[best] = 1'b1;
            walker_at        = POINT_BITS'(best);
            res.to_point     = walker_at;
            res.moved        = 1'b1;
            res.walk_done    = 1'b0;
          end else begin
            walk_over     = 1'b1;
            res.walk_done = 1'b1;
          end
        end
      end
      default: begin
        // The unused code leaves every piece of state alone.
      end
    endcase
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Command generation. Commands are queued by the initial block below and
  // handed to the block by the driver. Every point that a step may read is
  // loaded before the step is queued; loaded[] tracks this at queue time,
  // which is safe because transfers are accepted in queue order.
  // ---------------------------------------------------------------------------
  hgfp_pkg::hgfp_in_t  queued_commands [$];
  hgfp_pkg::hgfp_out_t predicted_moves [$];
  bit        loaded [MAX_POINTS];
  int        items_queued = 0;
  int        results_seen = 0;
  int        mismatches   = 0;
  bit        hold_req     = 1'b0;

  task automatic offer(hgfp_pkg::hgfp_cmd_t cmd, int idx, int h);
    hgfp_pkg::hgfp_in_t item;
    item.command      = cmd;
    item.point_index  = POINT_BITS'(idx);
    item.height_value = HEIGHT_BITS'(h);
    queued_commands = {queued_commands, item};
    items_queued++;
    if (cmd == hgfp_pkg::CMD_LOAD) loaded[idx] = 1'b1;
  endtask

  function automatic int terrain_height(terrain_t mode, int p);
    case (mode)
      // A narrow band against a tolerance of a few hundred gives long meandering walks.
      TERRAIN_BAND:  return $urandom_range(1000, 1200);
      // Equal heights make every candidate tie, so the neighbor order decides.
      TERRAIN_FLAT:  return 2000;
      TERRAIN_SLOPE: return 60000 - 9 * p + $urandom_range(0, 40);
      TERRAIN_CLIFF: return ($urandom_range(0, 1) != 0) ? 65535 : 0;
      default:       return $urandom_range(0, 65535);
    endcase
  endfunction

  task automatic shape_terrain(terrain_t mode, int upto);
    for (int p = 0; p < upto; p++) offer(hgfp_pkg::CMD_LOAD, p, terrain_height(mode, p));
  endtask

  // Loads every point inside the current grid that has never been written.
  task automatic fill_unloaded();
    for (int p = 0; p < eff_total(); p++)
      if (!loaded[p]) offer(hgfp_pkg::CMD_LOAD, p, terrain_height(TERRAIN_NOISE, p));
  endtask

  // Loads the unwritten points within reach of a walk whose every neighbor lies one
  // index away (a single column, or rows wider than the grid).
  task automatic fill_around(int from, int steps);
    for (int p = from - steps - 1; p <= from + steps + 1; p++)
      if (p >= 0 && p < MAX_POINTS && !loaded[p])
        offer(hgfp_pkg::CMD_LOAD, p, terrain_height(TERRAIN_NOISE, p));
  endtask

  function automatic int pick_start();
    int p;
    if (eff_total() > 0 && $urandom_range(0, 7) != 0) p = $urandom_range(0, eff_total() - 1);
    else p = $urandom_range(0, MAX_POINTS - 1);
    if (!loaded[p]) p = 0;
    return p;
  endfunction

  // A well-formed walk: one start and a run of steps, now and then with a load
  // slipped in before a step. The unused fields of a step carry noise.
  task automatic trace_walk(int from, int steps);
    offer(hgfp_pkg::CMD_START, from, $urandom_range(0, 65535));
    repeat (steps) begin
      if ($urandom_range(0, 15) == 0)
        offer(hgfp_pkg::CMD_LOAD, $urandom_range(0, MAX_POINTS - 1),
              $urandom_range(0, 65535));
      offer(hgfp_pkg::CMD_STEP, $urandom_range(0, MAX_POINTS - 1), $urandom_range(0, 65535));
    end
  endtask

  task automatic run_walks(int budget);
    int spent;
    int pick;
    int steps;
    spent = 0;
    while (spent < budget) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        offer(CMD_UNUSED, $urandom_range(0, MAX_POINTS - 1), $urandom_range(0, 65535));
        spent++;
      end else if (pick == 1) begin
        offer(hgfp_pkg::CMD_STEP, $urandom_range(0, MAX_POINTS - 1), $urandom_range(0, 65535));
        spent++;
      end else if (pick == 2) begin
        offer(hgfp_pkg::CMD_LOAD, $urandom_range(0, MAX_POINTS - 1), $urandom_range(0, 65535));
        spent++;
      end else begin
        steps = $urandom_range(1, 30);
        trace_walk(pick_start(), steps);
        spent = spent + steps + 1;
      end
    end
  endtask

  // Waits until every queued command has produced its result.
  task automatic drain();
    while (results_seen != items_queued) @(posedge clk);
  endtask

  // Writes all three registers while the block is idle. The model copy is
  // updated together with the port, before the next command can arrive.
  task automatic set_config(int row, int total, int tol);
    drain();
    repeat (2) @(posedge clk);
    @(negedge clk);
    cfg_we      <= 1'b1;
    cfg_index   <= hgfp_pkg::CFG_ROW_LENGTH;
    cfg_wdata   <= hgfp_pkg::CFG_DATA_BITS'(row);
    row_len_set  = ROW_BITS'(row);
    @(negedge clk);
    cfg_index   <= hgfp_pkg::CFG_POINT_TOTAL;
    cfg_wdata   <= hgfp_pkg::CFG_DATA_BITS'(total);
    total_set    = ROW_BITS'(total);
    @(negedge clk);
    cfg_index   <= hgfp_pkg::CFG_CLIMB_TOL;
    cfg_wdata   <= hgfp_pkg::CFG_DATA_BITS'(tol);
    climb_set    = TOL_BITS'(tol);
    @(negedge clk);
    cfg_we      <= 1'b0;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Driver. The payload changes only at a falling edge after the previous
  // transfer was taken, so a stalled payload holds still. Commands go out in
  // bursts of random length with random gaps between them, and runs of zero
  // gaps keep the input busy back to back.
  // ---------------------------------------------------------------------------
  bit in_taken   = 1'b0;
  int burst_left = 0;
  int gap_left   = 0;

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      in_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (queued_commands.size() > 0) begin
        in_data  <= queued_commands.pop_front();
        in_valid <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          case ($urandom_range(0, 9))
            0, 1, 2, 3: gap_left = 0;
            4, 5, 6:    gap_left = $urandom_range(1, 4);
            7, 8:       gap_left = $urandom_range(5, 20);
            default:    gap_left = $urandom_range(20, 60);
          endcase
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver. It stalls on a pattern that is redrawn at random: never,
  // rarely, mostly, or toggling. On request it holds off for a
  // long stretch so the block backs up and stalls its own input.
  // ---------------------------------------------------------------------------
  int stall_mode = 0;
  int mode_left  = 0;
  int hold_left  = 0;

  always @(negedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(20, 200);
      end
      mode_left--;
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        2:       out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= ~out_stall;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Both channels are sampled at the rising edge. An accepted input transfer
  // advances the model and queues its predicted result first, so the check of
  // an output transfer in the same edge always finds it. The watchdog counts
  // cycles in which neither channel moves anything.
  // ---------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin : transfer_watch
    hgfp_pkg::hgfp_out_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predicted_moves = {predicted_moves, predict_move(in_data)};
        in_taken = 1'b1;
      end
      if (out_valid && !out_stall) begin
        if (predicted_moves.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("unexpected result: from %0d to %0d moved %0b done %0b",
                     out_data.from_point, out_data.to_point, out_data.moved,
                     out_data.walk_done);
        end else begin
          want = predicted_moves.pop_front();
          results_seen++;
          if (out_data.from_point != want.from_point || out_data.to_point != want.to_point ||
              out_data.moved != want.moved || out_data.walk_done != want.walk_done) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
              $display("result %0d: expected from %0d to %0d moved %0b done %0b,",
                       results_seen, want.from_point, want.to_point, want.moved,
                       want.walk_done,
                       " got from %0d to %0d moved %0b done %0b",
                       out_data.from_point, out_data.to_point,
                       out_data.moved, out_data.walk_done);
          end
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("testbench: errors");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------
  initial begin
    int       phase;
    terrain_t mode;
    int       row, total, tol;
    int       start_at;

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part on a 4 x 4 grid with no climbing allowed. A step before any
    // walk and the unused code report the idle walker; a load far outside the
    // grid writes the top index with the top height.
    set_config(4, 16, 0);
    offer(hgfp_pkg::CMD_STEP, 0, 0);
    offer(CMD_UNUSED, MAX_POINTS - 1, 65535);
    offer(hgfp_pkg::CMD_LOAD, MAX_POINTS - 1, 65535);
    // Flat plateau with a pit and a peak: ties everywhere, one deep drop and one
    // neighbor too high to climb.
    for (int p = 0; p < 16; p++)
      offer(hgfp_pkg::CMD_LOAD, p, (p == 15) ? 0 : ((p == 12) ? 65535 : 500));
    // From the middle the walk may step straight back onto its unmarked start point.
    offer(hgfp_pkg::CMD_START, 5, 0);
    repeat (6) offer(hgfp_pkg::CMD_STEP, 0, 0);
    // A walk that starts outside the grid has no neighbor inside it; the second
    // step then reports the finished walk again.
    offer(hgfp_pkg::CMD_START, MAX_POINTS - 1, 0);
    offer(hgfp_pkg::CMD_STEP, 0, 0);
    offer(hgfp_pkg::CMD_STEP, 0, 0);

    // Zero row length acts as one column and an oversized total as the whole store;
    // each walk only reaches the points right around its start, which are loaded first.
    set_config(0, 8191, 65535);
    fill_around(2000, 12);
    trace_walk(2000, 12);
    start_at = $urandom_range(200, 3800);
    fill_around(start_at, 12);
    trace_walk(start_at, 12);

    // Single valid point with rows as wide as the store: nothing is ever eligible.
    set_config(4096, 1, 65535);
    trace_walk(0, 2);
    trace_walk(MAX_POINTS - 1, 2);
    // Largest register values for row length, and a single-column walk.
    set_config(8191, 4096, 0);
    fill_around(100, 5);
    trace_walk(100, 5);
    set_config(1, 4096, 300);
    start_at = $urandom_range(200, 3800);
    fill_around(start_at, 10);
    trace_walk(start_at, 10);

    // A storm of starts wraps the block's walk tag. The receiver holds off at the
    // same time so the block backs up behind it.
    set_config(4, 16, 100);
    hold_req = 1'b1;
    for (int k = 0; k < 270; k++) begin
      offer(hgfp_pkg::CMD_START, pick_start(), $urandom_range(0, 65535));
      if (k % 16 == 0) repeat (2) offer(hgfp_pkg::CMD_STEP, 0, 0);
    end

    // Random phases: each one drains, picks a new configuration, reshapes the
    // low part of the grid and runs walks over it.
    phase = 0;
    while (items_queued < TOTAL_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       row = 0;
        1:       row = 1;
        2:       row = 4096;
        3:       row = 8191;
        default: row = $urandom_range(2, 80);
      endcase
      case ($urandom_range(0, 11))
        0:       total = 0;
        1:       total = 1;
        2:       total = 300;
        default: total = $urandom_range(2, 300);
      endcase
      case ($urandom_range(0, 7))
        0:       tol = 0;
        1:       tol = 65535;
        2:       tol = $urandom_range(0, 65535);
        default: tol = $urandom_range(0, 300);
      endcase
      set_config(row, total, tol);
      if (phase == 0 || $urandom_range(0, 3) == 0) hold_req = 1'b1;
      mode = ($urandom_range(0, 9) < 4) ? TERRAIN_BAND : terrain_t'($urandom_range(0, 4));
      shape_terrain(mode, (eff_total() < SHAPED_POINTS) ? eff_total() : SHAPED_POINTS);
      fill_unloaded();
      run_walks($urandom_range(40, 120));
      phase++;
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && predicted_moves.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
